### src/gcdci_pkg.sv
// Shared types, widths and helpers for the GCD consecutive-integer check block.
// No dependencies; imported by gcdci_core and gcd_consecutive_integer_check.
`timescale 1ns / 1ps
`default_nettype none

package gcdci_pkg;

    localparam int WIDTH   = 32;
    localparam int KW      = $clog2(WIDTH);
    localparam int IN_BITS = 2 * WIDTH;

    typedef logic [WIDTH-1:0] word_t;
    typedef logic [KW-1:0]    shift_cnt_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_SCALE,
        ST_DONE
    } core_state_t;

    // Magnitude of a two's complement word; the most negative value keeps its full weight
    function automatic word_t magnitude(input word_t v);
        word_t m;
        m = v[WIDTH-1] ? (~v + word_t'(1)) : v;
        return m;
    endfunction

endpackage

`default_nettype wire

### src/gcdci_core.sv
// Sequenced GCD datapath: one shared compare/subtract/shift unit under a small FSM.
// Depends on gcdci_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gcdci_core
    import gcdci_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire word_t first_in,
    input  wire word_t second_in,
    input  wire logic  take,
    output logic       idle,
    output logic       done,
    output word_t      result
);

    core_state_t state_reg, state_next;
    word_t       a_reg, a_next;
    word_t       b_reg, b_next;
    shift_cnt_t  k_reg, k_next;

    logic  a_gt;
    word_t big, sml, diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        k_reg <= k_next;
    end

    // Shared subtractor: larger minus smaller
    always_comb
    begin
        a_gt = a_reg > b_reg;
        big  = a_gt ? a_reg : b_reg;
        sml  = a_gt ? b_reg : a_reg;
        diff = big - sml;
    end

    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    a_next = magnitude(first_in);
                    b_next = magnitude(second_in);
                    k_next = '0;
                    if (first_in == '0 || second_in == '0)
                    begin
                        a_next     = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                // Strip shared twos first, then single twos, then subtract
                priority if (!a_reg[0] && !b_reg[0])
                begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + shift_cnt_t'(1);
                end
                else if (!a_reg[0])
                begin
                    a_next = a_reg >> 1;
                end
                else if (!b_reg[0])
                begin
                    b_next = b_reg >> 1;
                end
                else if (a_reg == b_reg)
                begin
                    state_next = (k_reg == '0) ? ST_DONE : ST_SCALE;
                end
                else if (a_gt)
                begin
                    a_next = diff;
                end
                else
                begin
                    b_next = diff;
                end
            end
            ST_SCALE:
            begin
                // Restore the shared power of two, one bit a cycle
                if (k_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    a_next = a_reg << 1;
                    k_next = k_reg - shift_cnt_t'(1);
                end
            end
            ST_DONE:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign idle   = (state_reg == ST_IDLE);
    assign done   = (state_reg == ST_DONE);
    assign result = a_reg;

endmodule

`default_nettype wire

### src/gcd_consecutive_integer_check.sv
// Top level: stream ports, output register and the sequenced GCD core.
// Depends on gcdci_pkg and gcdci_core.
//
//  channel   dir  beat contents
//  s_axis    in   tdata[31:0] first_value, tdata[63:32] second_value (signed)
//  m_axis    out  tdata[31:0] divisor (unsigned), one beat per input beat
//
// One beat at a time: the core takes a pair, then runs a binary GCD on one shared
// compare/subtract/shift unit. A zero operand skips the run and gives a zero result;
// otherwise the run is data dependent, made of shifts plus subtractions plus the
// shared power of two restored at the end. Reset clears the sequencer and output
// valid only. s_axis_tready is low while the core works; a finished result waits
// in the core until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module gcd_consecutive_integer_check
    import gcdci_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [IN_BITS-1:0] s_axis_tdata,  // first_value, second_value
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [WIDTH-1:0]        m_axis_tdata   // divisor
);

    logic  core_idle;
    logic  core_done;
    word_t core_result;
    logic  in_beat;
    logic  out_free;
    logic  take;

    logic  m_tvalid_reg, m_tvalid_next;
    word_t m_tdata_reg, m_tdata_next;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_tvalid_reg || m_axis_tready;
    assign take     = core_done && out_free;

    gcdci_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_beat),
        .first_in  (s_axis_tdata[WIDTH-1:0]),
        .second_in (s_axis_tdata[IN_BITS-1:WIDTH]),
        .take      (take),
        .idle      (core_idle),
        .done      (core_done),
        .result    (core_result)
    );

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (take)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = core_result;
        end
        else if (m_axis_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign s_axis_tready = core_idle;
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    // Hand-off from the core always lands in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        take |=> m_axis_tvalid)
        else $error("core result not registered");

    // Accepting a beat makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !s_axis_tready)
        else $error("block still ready after accepting a beat");

    // A zero first operand goes straight to a finished zero result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && (s_axis_tdata[WIDTH-1:0] == '0) |=> core_done && (core_result == '0))
        else $error("zero operand did not give zero");

endmodule

`default_nettype wire
